[rtl/core/sfp_pkg.sv]
// Shared types and constants for the start-of-frame byte parser.
package sfp_pkg;

  // Input word kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Start word after reset
  localparam logic [15:0] SYNC_RESET = 16'hAA55;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SOF1 = 4'd0,
    PH_SOF2 = 4'd1,
    PH_LEN  = 4'd2,
    PH_TYPE = 4'd3,
    PH_DST  = 4'd4,
    PH_SRC  = 4'd5,
    PH_SEQ1 = 4'd6,
    PH_SEQ2 = 4'd7,
    PH_DATA = 4'd8,
    PH_CHK1 = 4'd9,
    PH_CHK2 = 4'd10,
    PH_DONE = 4'd11
  } phase_t;

  // One result word
  typedef struct packed {
    logic        accepted;
    logic        frame_ready;
    logic [7:0]  payload_length;
    logic [7:0]  frame_type;
    logic [7:0]  destination;
    logic [7:0]  source;
    logic [15:0] sequence_res;
    logic [15:0] check_value;
    logic [7:0]  data_byte;
    logic        data_valid;
  } result_t;

endpackage

[rtl/core/sof_frame_byte_parser_top.sv]
// Top level of the start-of-frame byte parser.
//
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------------
//  config   cfg_write              cfg_data (start word, high byte first)
//  input    in_valid / in_stall    kind, byte_value, payload_index
//  output   out_valid / out_stall  accepted, frame_ready, header fields,
//                                  check_value, data_byte, data_valid
//
// One word per cycle sustained unless the input stalls. A word is parsed and the
// payload store written or read in the cycle it is accepted; its result then passes
// through the result register and a two-word output queue to the output.
// rst is synchronous: parser goes to start-byte hunt, start word to 0xAA55.
// The payload store is not cleared. Input stalls only when the queue is full
// and the result register is occupied.
module sof_frame_byte_parser_top #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  payload_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        frame_ready,
  output logic [7:0]  payload_length,
  output logic [7:0]  frame_type,
  output logic [7:0]  destination,
  output logic [7:0]  source,
  output logic [15:0] sequence_res,
  output logic [15:0] check_value,
  output logic [7:0]  data_byte,
  output logic        data_valid
);

  logic [15:0]      sync_word;
  logic             take;
  logic             res_valid;
  logic             buf_full;
  logic             res_take;
  sfp_pkg::result_t res;
  sfp_pkg::result_t out_word;

  // Start word register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= sfp_pkg::SYNC_RESET;
    end else if (cfg_write) begin
      sync_word <= cfg_data;
    end
  end

  // Flow control
  assign res_take = res_valid && !buf_full;
  assign in_stall = res_valid && buf_full;
  assign take     = in_valid && !in_stall;

  sfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .sync_word     (sync_word),
    .take          (take),
    .kind          (kind),
    .byte_value    (byte_value),
    .payload_index (payload_index),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  sfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_take),
    .push_word (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Output fields
  assign accepted       = out_word.accepted;
  assign frame_ready    = out_word.frame_ready;
  assign payload_length = out_word.payload_length;
  assign frame_type     = out_word.frame_type;
  assign destination    = out_word.destination;
  assign source         = out_word.source;
  assign sequence_res   = out_word.sequence_res;
  assign check_value    = out_word.check_value;
  assign data_byte      = out_word.data_byte;
  assign data_valid     = out_word.data_valid;

endmodule

[rtl/core/sfp_parser.sv]
// Parser state, payload store and result register.
module sfp_parser #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      sync_word,
  input  logic             take,
  input  logic [1:0]       kind,
  input  logic [7:0]       byte_value,
  input  logic [7:0]       payload_index,
  output logic             res_valid,
  input  logic             res_take,
  output sfp_pkg::result_t res
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD);

  // Frame state
  sfp_pkg::phase_t phase, phase_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  dest_reg, dest_reg_next;
  logic [7:0]  source_reg, source_reg_next;
  logic [15:0] sequence_reg, sequence_reg_next;
  logic [15:0] check_reg, check_reg_next;

  logic        acc;
  logic        dvalid;
  logic        wr_en;
  logic        clr;
  logic        ready_next;

  // Payload store, registered read
  logic [7:0]  store [MAX_PAYLOAD];
  logic [7:0]  rd_q;

  // Result register (data byte comes from rd_q)
  logic        r_acc;
  logic        r_ready;
  logic [7:0]  r_len;
  logic [7:0]  r_type;
  logic [7:0]  r_dest;
  logic [7:0]  r_src;
  logic [15:0] r_seq;
  logic [15:0] r_chk;
  logic        r_dvalid;

  // Next state for one word
  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    length_reg_next    = length_reg;
    type_reg_next      = type_reg;
    dest_reg_next      = dest_reg;
    source_reg_next    = source_reg;
    sequence_reg_next  = sequence_reg;
    check_reg_next     = check_reg;
    acc                = 1'b0;
    dvalid             = 1'b0;
    wr_en              = 1'b0;
    clr                = 1'b0;

    unique case (kind)
      sfp_pkg::KIND_BYTE: begin
        acc = 1'b1;
        unique case (phase)
          sfp_pkg::PH_SOF1: begin
            if (byte_value != sync_word[15:8]) begin
              clr = 1'b1;
              acc = 1'b0;
            end else begin
              phase_next = sfp_pkg::PH_SOF2;
            end
          end
          sfp_pkg::PH_SOF2: begin
            // no recheck against the first start byte here
            if (byte_value != sync_word[7:0]) begin
              clr = 1'b1;
              acc = 1'b0;
            end else begin
              phase_next = sfp_pkg::PH_LEN;
            end
          end
          sfp_pkg::PH_LEN: begin
            if ({1'b0, byte_value} > LEN_LIMIT) begin
              clr = 1'b1;
              acc = 1'b0;
            end else begin
              length_reg_next = byte_value;
              phase_next      = sfp_pkg::PH_TYPE;
            end
          end
          sfp_pkg::PH_TYPE: begin
            type_reg_next = byte_value;
            phase_next    = sfp_pkg::PH_DST;
          end
          sfp_pkg::PH_DST: begin
            dest_reg_next = byte_value;
            phase_next    = sfp_pkg::PH_SRC;
          end
          sfp_pkg::PH_SRC: begin
            source_reg_next = byte_value;
            phase_next      = sfp_pkg::PH_SEQ1;
          end
          sfp_pkg::PH_SEQ1: begin
            sequence_reg_next = {byte_value, 8'h00};
            phase_next        = sfp_pkg::PH_SEQ2;
          end
          sfp_pkg::PH_SEQ2: begin
            sequence_reg_next = {sequence_reg[15:8], byte_value};
            phase_next        = sfp_pkg::PH_DATA;
          end
          sfp_pkg::PH_DATA: begin
            // payload until length reached, then checksum high byte
            if (payload_count < length_reg) begin
              wr_en              = 1'b1;
              payload_count_next = payload_count + 8'd1;
            end else begin
              check_reg_next = {byte_value, 8'h00};
              phase_next     = sfp_pkg::PH_CHK2;
            end
          end
          sfp_pkg::PH_CHK1: begin
            check_reg_next = {byte_value, 8'h00};
            phase_next     = sfp_pkg::PH_CHK2;
          end
          sfp_pkg::PH_CHK2: begin
            check_reg_next = {check_reg[15:8], byte_value};
            phase_next     = sfp_pkg::PH_DONE;
          end
          sfp_pkg::PH_DONE: begin
            acc = 1'b0;
          end
          default: begin
            clr = 1'b1;
            acc = 1'b0;
          end
        endcase
      end
      sfp_pkg::KIND_READ: begin
        dvalid = (phase == sfp_pkg::PH_DONE) && (payload_index < length_reg);
        acc    = dvalid;
      end
      sfp_pkg::KIND_CLEAR: begin
        clr = 1'b1;
        acc = 1'b1;
      end
      default: begin
      end
    endcase

    if (clr) begin
      phase_next         = sfp_pkg::PH_SOF1;
      payload_count_next = 8'd0;
      length_reg_next    = 8'd0;
      type_reg_next      = 8'd0;
      dest_reg_next      = 8'd0;
      source_reg_next    = 8'd0;
      sequence_reg_next  = 16'd0;
      check_reg_next     = 16'd0;
    end

    ready_next = (phase_next == sfp_pkg::PH_DONE);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfp_pkg::PH_SOF1;
      payload_count <= 8'd0;
      length_reg    <= 8'd0;
      type_reg      <= 8'd0;
      dest_reg      <= 8'd0;
      source_reg    <= 8'd0;
      sequence_reg  <= 16'd0;
      check_reg     <= 16'd0;
    end else if (take) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      length_reg    <= length_reg_next;
      type_reg      <= type_reg_next;
      dest_reg      <= dest_reg_next;
      source_reg    <= source_reg_next;
      sequence_reg  <= sequence_reg_next;
      check_reg     <= check_reg_next;
    end
  end

  // Payload memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      store[payload_count[AW-1:0]] <= byte_value;
    end
    if (take) begin
      rd_q <= store[payload_index[AW-1:0]];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      r_acc    <= acc;
      r_ready  <= ready_next;
      r_len    <= ready_next ? length_reg_next   : 8'd0;
      r_type   <= ready_next ? type_reg_next     : 8'd0;
      r_dest   <= ready_next ? dest_reg_next     : 8'd0;
      r_src    <= ready_next ? source_reg_next   : 8'd0;
      r_seq    <= ready_next ? sequence_reg_next : 16'd0;
      r_chk    <= ready_next ? check_reg_next    : 16'd0;
      r_dvalid <= dvalid;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    res.accepted       = r_acc;
    res.frame_ready    = r_ready;
    res.payload_length = r_len;
    res.frame_type     = r_type;
    res.destination    = r_dest;
    res.source         = r_src;
    res.sequence_res   = r_seq;
    res.check_value    = r_chk;
    res.data_byte      = r_dvalid ? rd_q : 8'd0;
    res.data_valid     = r_dvalid;
  end

endmodule

[rtl/core/sfp_out_buf.sv]
// Two-word output queue between the result register and the output port.
module sfp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfp_pkg::result_t push_word,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output sfp_pkg::result_t out_word
);

  sfp_pkg::result_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_word  = slot[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
